// ----- sv/giq_pkg.sv -----
// ----------------------------------------------------------------------------
// giq_pkg
// shared types and constants of the gene interval overlap query block
// ----------------------------------------------------------------------------
package giq_pkg;

    localparam int COORD_BITS  = 40;
    localparam int SLOT_BITS   = 16;
    localparam int IDENT_BITS  = 20;
    localparam int ALIGN_BITS  = 8;
    localparam int LEN_BITS    = 32;
    localparam int COUNT_BITS  = 17;
    localparam int FILTER_BITS = 2;
    localparam int CFG_W       = 17;
    localparam int END_BITS    = COORD_BITS + 1;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] CMD_LOAD     = 2'd0;
    localparam logic [1:0] CMD_NEW_READ = 2'd1;
    localparam logic [1:0] CMD_QUERY    = 2'd2;

    localparam logic CFG_FILTER = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    localparam logic [FILTER_BITS-1:0] FILTER_ANY  = 2'b11;
    localparam logic [FILTER_BITS-1:0] FILTER_NONE = 2'b10;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [SLOT_BITS-1:0]  gene_slot;
        logic [COORD_BITS-1:0] gene_start;
        logic [COORD_BITS-1:0] gene_end;
        logic [COORD_BITS-1:0] gene_max_end;
        logic                  gene_strand;
        logic [IDENT_BITS-1:0] gene_ident;
        logic [ALIGN_BITS-1:0] align_number;
        logic [COORD_BITS-1:0] block_start;
        logic [LEN_BITS-1:0]   block_length;
        logic                  align_strand;
        logic                  first_block;
    } t_req;

    typedef struct packed {
        logic [IDENT_BITS-1:0] hit_gene;
        logic [ALIGN_BITS-1:0] hit_align;
        logic                  new_for_read;
        logic                  hit_valid;
        logic                  set_overflow;
        logic                  last;
    } t_rsp;

    typedef struct packed {
        logic [COORD_BITS-1:0] start_pos;
        logic [COORD_BITS-1:0] end_pos;
        logic [COORD_BITS-1:0] max_end;
        logic                  strand;
        logic [IDENT_BITS-1:0] ident;
    } t_row;

    typedef struct packed {
        logic [1:0]            cmd;
        logic                  slot_ok;
        logic [SLOT_BITS-1:0]  slot;
        t_row                  row;
        logic [ALIGN_BITS-1:0] align_number;
        logic [COORD_BITS-1:0] block_start;
        logic [END_BITS-1:0]   block_end;
        logic                  no_end;
        logic                  align_strand;
        logic                  first_block;
    } t_job;

    typedef struct packed {
        logic [FILTER_BITS-1:0] strand_filter;
        logic [COUNT_BITS-1:0]  gene_count;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAST,
        ST_FIRST,
        ST_STEP,
        ST_BIN,
        ST_FWD,
        ST_WALK,
        ST_TERM
    } t_state;

endpackage

// ----- sv/gene_interval_overlap_query.sv -----
// ----------------------------------------------------------------------------
// gene_interval_overlap_query
// sorted gene table with binary search and running max end overlap walk
// ----------------------------------------------------------------------------
//  channel   | handshake                  | payload
//  request   | i_req_valid / o_req_ready  | i_req (t_req)
//  response  | o_rsp_valid / i_rsp_ready  | o_rsp (t_rsp)
//  config    | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
//  a load or new-read request is handled in the idle state of the engine
//  a query pops, checks the table ends, binary searches, steps over entries
//  with an equal start, walks back over entries and ends with a terminator;
//  the single table read port serialises these steps
//  requests queue up to 4 deep ahead of the engine
//  a full response register stalls the walk; reset is synchronous, active low
// ----------------------------------------------------------------------------
module gene_interval_overlap_query
    import giq_pkg::*;
#(
    parameter int GENE_DEPTH = 65536,
    parameter int SET_DEPTH  = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  t_req             i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output t_rsp             o_rsp,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic push, full, pop, q_valid;
    t_job job, q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strand_filter <= FILTER_ANY;
            r_cfg.gene_count    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FILTER: r_cfg.strand_filter <= i_cfg_data[FILTER_BITS-1:0];
                CFG_COUNT:  r_cfg.gene_count    <= i_cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    giq_front #(
        .GENE_DEPTH(GENE_DEPTH)
    ) u_front (
        .i_req_valid(i_req_valid),
        .i_req      (i_req),
        .o_req_ready(o_req_ready),
        .i_full     (full),
        .o_push     (push),
        .o_job      (job)
    );

    giq_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (job),
        .o_full (full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_job  (q_job)
    );

    giq_back #(
        .GENE_DEPTH(GENE_DEPTH),
        .SET_DEPTH (SET_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_q_job    (q_job),
        .o_q_pop    (pop),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp      (o_rsp)
    );

endmodule

// ----- sv/giq_front.sv -----
// ----------------------------------------------------------------------------
// giq_front
// accepts requests, checks load slots and forms the block end for queries
// ----------------------------------------------------------------------------
module giq_front
    import giq_pkg::*;
#(
    parameter int GENE_DEPTH = 65536
) (
    input  logic i_req_valid,
    input  t_req i_req,
    output logic o_req_ready,
    input  logic i_full,
    output logic o_push,
    output t_job o_job
);

    localparam int WIDE = 21;

    logic [WIDE-1:0] slot_wide;

    assign slot_wide   = WIDE'(i_req.gene_slot);
    assign o_req_ready = !i_full;
    assign o_push      = i_req_valid && !i_full;

    always_comb begin
        o_job.cmd           = i_req.cmd;
        o_job.slot          = i_req.gene_slot;
        o_job.slot_ok       = slot_wide < WIDE'(GENE_DEPTH);
        o_job.row.start_pos = i_req.gene_start;
        o_job.row.end_pos   = i_req.gene_end;
        o_job.row.max_end   = i_req.gene_max_end;
        o_job.row.strand    = i_req.gene_strand;
        o_job.row.ident     = i_req.gene_ident;
        o_job.align_number  = i_req.align_number;
        o_job.block_start   = i_req.block_start;
        // zero length gives start - 1, one extra bit holds the carry
        o_job.block_end     = END_BITS'(i_req.block_start) + END_BITS'(i_req.block_length)
                              - END_BITS'(1);
        o_job.no_end        = (i_req.block_length == '0) && (i_req.block_start == '0);
        o_job.align_strand  = i_req.align_strand;
        o_job.first_block   = i_req.first_block;
    end

endmodule

// ----- sv/giq_queue.sv -----
// ----------------------------------------------------------------------------
// giq_queue
// small request queue between the front and the search engine
// ----------------------------------------------------------------------------
module giq_queue
    import giq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = r_cnt == CW'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ----- sv/giq_back.sv -----
// ----------------------------------------------------------------------------
// giq_back
// gene table, binary search, backward walk, hit sets and result register
// ----------------------------------------------------------------------------
module giq_back
    import giq_pkg::*;
#(
    parameter int GENE_DEPTH = 65536,
    parameter int SET_DEPTH  = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_q_valid,
    input  t_job i_q_job,
    output logic o_q_pop,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int ADDR_W = $clog2(GENE_DEPTH);
    localparam int IW     = ADDR_W + 1;
    localparam int WIDE   = 21;
    localparam int SW     = $clog2(SET_DEPTH + 1);
    localparam int ROW_W  = $bits(t_row);

    logic [ROW_W-1:0]      r_mem [GENE_DEPTH];
    t_row                  r_row;
    t_state                r_state, n_state;
    t_job                  r_job, n_job;
    logic [IW-1:0]         r_lo, n_lo, r_hi, n_hi, r_mid, n_mid, r_gi, n_gi;
    logic                  r_ovf, n_ovf;
    logic [SW-1:0]         r_asize, r_rsize;
    logic [IDENT_BITS-1:0] r_aset [SET_DEPTH];
    logic [IDENT_BITS-1:0] r_rset [SET_DEPTH];
    t_rsp                  r_out;
    logic                  r_out_valid;

    logic [ADDR_W-1:0]     rd_addr;
    logic                  mem_we, clr_a, clr_r, add_a, add_r, emit, can_emit;
    t_rsp                  emit_rsp;
    logic [WIDE-1:0]       cnt_wide, n_wide;
    logic [IW-1:0]         n_cnt, n_last, mid_calc;
    logic [END_BITS-1:0]   row_start;
    logic                  reach, end_ok, rel, pass, cand, in_a, in_r, full;

    assign cnt_wide  = WIDE'(i_cfg.gene_count);
    assign n_wide    = (cnt_wide > WIDE'(GENE_DEPTH)) ? WIDE'(GENE_DEPTH) : cnt_wide;
    assign n_cnt     = n_wide[IW-1:0];
    assign n_last    = n_cnt - IW'(1);
    assign mid_calc  = r_lo + ((r_hi - r_lo) >> 1);
    assign row_start = END_BITS'(r_row.start_pos);
    assign can_emit  = !r_out_valid || i_rsp_ready;

    // hit tests on the entry under the walk pointer
    assign reach  = r_row.max_end >= r_job.block_start;
    assign end_ok = r_row.end_pos >= r_job.block_start;
    assign rel    = r_row.strand ? r_job.align_strand : !r_job.align_strand;
    assign pass   = (i_cfg.strand_filter == FILTER_ANY) ||
                    (!i_cfg.strand_filter[1] && (i_cfg.strand_filter[0] == rel));
    assign cand   = end_ok && pass;

    always_comb begin
        in_a = 1'b0;
        in_r = 1'b0;
        for (int i = 0; i < SET_DEPTH; i++) begin
            if ((SW'(i) < r_asize) && (r_aset[i] == r_row.ident)) begin
                in_a = 1'b1;
            end
            if ((SW'(i) < r_rsize) && (r_rset[i] == r_row.ident)) begin
                in_r = 1'b1;
            end
        end
    end

    assign full = (r_asize >= SW'(SET_DEPTH)) || (!in_r && (r_rsize >= SW'(SET_DEPTH)));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_q_job.slot[ADDR_W-1:0]] <= i_q_job.row;
        end
        r_row <= r_mem[rd_addr];
    end

    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_gi     = r_gi;
        n_ovf    = r_ovf;
        rd_addr  = r_gi[ADDR_W-1:0];
        o_q_pop  = 1'b0;
        mem_we   = 1'b0;
        clr_a    = 1'b0;
        clr_r    = 1'b0;
        add_a    = 1'b0;
        add_r    = 1'b0;
        emit     = 1'b0;
        emit_rsp = '0;
        case (r_state)
            ST_IDLE: begin
                rd_addr = n_last[ADDR_W-1:0];
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_job   = i_q_job;
                    n_ovf   = 1'b0;
                    case (i_q_job.cmd)
                        CMD_LOAD: begin
                            mem_we = i_q_job.slot_ok;
                        end
                        CMD_NEW_READ: begin
                            clr_a = 1'b1;
                            clr_r = 1'b1;
                        end
                        CMD_QUERY: begin
                            clr_a = i_q_job.first_block;
                            if (i_q_job.no_end || n_cnt == '0) begin
                                n_state = ST_TERM;
                            end else begin
                                n_state = ST_LAST;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LAST: begin
                if (r_job.block_end > row_start) begin
                    n_gi    = n_last;
                    rd_addr = n_last[ADDR_W-1:0];
                    n_state = ST_WALK;
                end else begin
                    rd_addr = '0;
                    n_state = ST_FIRST;
                end
            end
            ST_FIRST: begin
                if (r_job.block_end < row_start) begin
                    n_state = ST_TERM;
                end else begin
                    n_lo    = '0;
                    n_hi    = n_last;
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                if (r_hi > r_lo + IW'(1)) begin
                    n_mid   = mid_calc;
                    rd_addr = mid_calc[ADDR_W-1:0];
                    n_state = ST_BIN;
                end else if (r_lo < n_last) begin
                    rd_addr = r_lo[ADDR_W-1:0] + ADDR_W'(1);
                    n_state = ST_FWD;
                end else begin
                    n_gi    = r_lo;
                    rd_addr = r_lo[ADDR_W-1:0];
                    n_state = ST_WALK;
                end
            end
            ST_BIN: begin
                if (row_start > r_job.block_end) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid;
                end
                n_state = ST_STEP;
            end
            ST_FWD: begin
                // step over entries with an equal start
                if (row_start == r_job.block_end) begin
                    n_lo    = r_lo + IW'(1);
                    n_state = ST_STEP;
                end else begin
                    n_gi    = r_lo;
                    rd_addr = r_lo[ADDR_W-1:0];
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!reach) begin
                    n_state = ST_TERM;
                end else if (cand && !in_a && !full && !can_emit) begin
                    n_state = ST_WALK;
                end else begin
                    if (cand && !in_a) begin
                        if (full) begin
                            n_ovf = 1'b1;
                        end else begin
                            add_a                 = 1'b1;
                            add_r                 = !in_r;
                            emit                  = 1'b1;
                            emit_rsp.hit_gene     = r_row.ident;
                            emit_rsp.hit_align    = r_job.align_number;
                            emit_rsp.new_for_read = !in_r;
                            emit_rsp.hit_valid    = 1'b1;
                        end
                    end
                    if (r_gi == '0) begin
                        n_state = ST_TERM;
                    end else begin
                        n_gi    = r_gi - IW'(1);
                        rd_addr = r_gi[ADDR_W-1:0] - ADDR_W'(1);
                    end
                end
            end
            ST_TERM: begin
                if (can_emit) begin
                    emit                  = 1'b1;
                    emit_rsp.hit_align    = r_job.align_number;
                    emit_rsp.set_overflow = r_ovf;
                    emit_rsp.last         = 1'b1;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_gi  <= n_gi;
        r_ovf <= n_ovf;
        if (emit) begin
            r_out <= emit_rsp;
        end
        for (int i = 0; i < SET_DEPTH; i++) begin
            if (add_a && SW'(i) == r_asize) begin
                r_aset[i] <= r_row.ident;
            end
            if (add_r && SW'(i) == r_rsize) begin
                r_rset[i] <= r_row.ident;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_asize     <= '0;
            r_rsize     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clr_a) begin
                r_asize <= '0;
            end else if (add_a) begin
                r_asize <= r_asize + SW'(1);
            end
            if (clr_r) begin
                r_rsize <= '0;
            end else if (add_r) begin
                r_rsize <= r_rsize + SW'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule
